// ===== sv/aecu_pkg.sv =====
// shared constants, curve codes and table builders for the easing curve unit
package aecu_pkg;

  localparam int FRAC_BITS_DEF       = 16;
  localparam int TABLE_ADDR_BITS_DEF = 8;

  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
  localparam logic [63:0] LN2_Q30     = 64'd744261118;
  localparam longint      Q30_ONE     = longint'(1) << 30;

  typedef enum logic [2:0] {
    OP_LINEAR = 3'd0,
    OP_SINE   = 3'd1,
    OP_CUBIC  = 3'd2,
    OP_EXPO   = 3'd3,
    OP_SPRING = 3'd4
  } op_t;

  // clamp a q30 value to [0, 1] and round half up to fb fraction bits
  function automatic logic [31:0] q30_round(longint v, int unsigned fb);
    longint c;
    c = v;
    if (c < 0) c = 0;
    if (c > Q30_ONE) c = Q30_ONE;
    return 32'((c + (longint'(1) << (29 - fb))) >>> (30 - fb));
  endfunction

  // sin(pi/2 * i / 2^ab) by taylor series in q30
  function automatic logic [31:0] sin_entry(int unsigned i, int unsigned fb, int unsigned ab);
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] term;
    longint      sum;
    x    = (HALF_PI_Q30 * 64'(i)) >> ab;
    x2   = (x * x) >> 30;
    term = x;
    sum  = longint'(x);
    for (int k = 1; k <= 12; k++) begin
      term = ((term * x2) >> 30) / 64'((2 * k) * (2 * k + 1));
      if (k[0]) sum = sum - longint'(term);
      else sum = sum + longint'(term);
    end
    if (i == 0) return 32'd0;
    if (i == (32'd1 << ab)) return 32'd1 << fb;
    return q30_round(sum, fb);
  endfunction

  // 2^(-i / 2^ab) as exp(-ln2 * i / 2^ab) by taylor series in q30
  function automatic logic [31:0] exp_entry(int unsigned i, int unsigned fb, int unsigned ab);
    logic [63:0] y;
    logic [63:0] term;
    longint      sum;
    y    = (LN2_Q30 * 64'(i)) >> ab;
    term = 64'(Q30_ONE);
    sum  = Q30_ONE;
    for (int k = 1; k <= 20; k++) begin
      term = ((term * y) >> 30) / 64'(k);
      if (k[0]) sum = sum - longint'(term);
      else sum = sum + longint'(term);
    end
    if (i == 0) return 32'd1 << fb;
    if (i == (32'd1 << ab)) return 32'd1 << (fb - 1);
    return q30_round(sum, fb);
  endfunction

endpackage

// ===== sv/animation_easing_curve_unit.sv =====
// easing curve unit: ten stage pipeline for linear, sine, cubic, expo and spring curves
//
//   channel  direction  ports                                   fields, lowest bit up
//   in       slave      in_tvalid in_tready in_tdata in_tuser   tdata: progress / tuser: operation
//   out      master     out_tvalid out_tready out_tdata         tdata: eased
//
// one transaction per cycle when nothing stalls
// the pipeline depth is set by the chain: phase reduction, divide by three through a reciprocal
// multiply, table read, interpolation multiply, envelope multiply, final select
// each stage has its own ready, so a stalled output fills bubbles before in_tready drops
// synchronous reset clears only the valid bits; data registers carry no reset
module animation_easing_curve_unit #(
  parameter int FRAC_BITS       = aecu_pkg::FRAC_BITS_DEF,
  parameter int TABLE_ADDR_BITS = aecu_pkg::TABLE_ADDR_BITS_DEF,
  localparam int InW  = ((FRAC_BITS + 8) / 8) * 8,
  localparam int OutW = ((FRAC_BITS + 9) / 8) * 8
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_tvalid,
  output logic            in_tready,
  input  logic [InW-1:0]  in_tdata,   // progress
  input  logic [2:0]      in_tuser,   // operation
  output logic            out_tvalid,
  input  logic            out_tready,
  output logic [OutW-1:0] out_tdata   // eased
);

  localparam int Fb     = FRAC_BITS;
  localparam int Ab     = TABLE_ADDR_BITS;
  localparam int Stages = 10;
  localparam int RomW   = Fb + 1;
  localparam int RomN   = (1 << Ab) + 1;
  localparam int KW     = Fb + Ab + 1;
  localparam int UW     = Fb + 4;
  localparam int N2W    = Fb + 6;
  localparam int PhW    = Fb + 4;
  localparam int QW     = Fb + 2;
  localparam int Sh     = Fb + 6;
  localparam int RecipW = Fb + 5;
  localparam int Vw     = Fb + 2;

  localparam logic [Fb:0]       One     = {1'b1, {Fb{1'b0}}};
  localparam logic [Fb:0]       Half    = One >> 1;
  localparam logic [Ab:0]       Last    = {1'b1, {Ab{1'b0}}};
  localparam logic [N2W-1:0]    NineOne = N2W'(9) << Fb;
  localparam logic [N2W-1:0]    P12     = N2W'(12) << Fb;
  localparam logic [N2W-1:0]    P24     = N2W'(24) << Fb;
  localparam logic [N2W-1:0]    P36     = N2W'(36) << Fb;
  localparam logic [N2W-1:0]    P48     = N2W'(48) << Fb;
  localparam logic [RecipW-1:0] Recip   = RecipW'((64'd1 << Sh) / 64'd3);
  localparam logic [Vw-1:0]     Hi      = {1'b0, {(Fb + 1){1'b1}}};

  typedef struct packed {
    logic [Fb:0]   t;
    logic [2:0]    op;
    logic [3:0]    un;
    logic [Fb-1:0] cube;
    logic          qhi;
  } side_t;

  logic [RomW-1:0] sin_tab [RomN];
  logic [RomW-1:0] exp_tab [RomN];

  for (genvar gi = 0; gi < RomN; gi++) begin : g_rom
    localparam logic [RomW-1:0] SinVal = RomW'(aecu_pkg::sin_entry(gi, Fb, Ab));
    localparam logic [RomW-1:0] ExpVal = RomW'(aecu_pkg::exp_entry(gi, Fb, Ab));
    assign sin_tab[gi] = SinVal;
    assign exp_tab[gi] = ExpVal;
  end

  logic [Stages-1:0] vld_r;
  logic [Stages-1:0] en;

  side_t side0_r, side1_r, side2_r, side3_r, side4_r, side5_r, side6_r, side7_r, side8_r;
  side_t side0_nxt, side1_nxt, side3_nxt, side5_nxt;

  logic [Fb-1:0]      uf1_r, uf2_r, uf3_r, uf4_r;
  logic [N2W-1:0]     n2_1_r;
  logic [Fb-1:0]      x1_r, x2_r;
  logic [PhW-1:0]     ph2_r, ph3_r;
  logic [Fb-1:0]      xx2_r;
  logic [QW-1:0]      q0_3_r, q4_r;
  logic [RomW-1:0]    sa5_r, sd5_r, ea5_r, ed5_r;
  logic               sdn5_r, edn5_r;
  logic [Fb-1:0]      sr5_r, er5_r;
  logic [RomW-1:0]    sa6_r, ea6_r;
  logic               sdn6_r, edn6_r;
  logic [2*Fb:0]      sprod6_r, eprod6_r;
  logic [RomW-1:0]    s7_r, e7_r, s8_r, e8_r;
  logic [RomW-1:0]    mag8_r;
  logic [Vw-1:0]      out_eased_r;

  logic [Fb:0]        t_in;
  logic [UW-1:0]      u_nxt;
  logic [N2W-1:0]     n2_nxt;
  logic [Fb-1:0]      x_nxt;
  logic [N2W-1:0]     wrap_sel;
  logic [PhW-1:0]     ph_nxt;
  logic [2*Fb-1:0]    xsq;
  logic [PhW+RecipW-1:0] qprod;
  logic [2*Fb-1:0]    cprod;
  logic [PhW-1:0]     q3m, rem;
  logic [QW-1:0]      q_nxt;
  logic [1:0]         quad;
  logic [Fb:0]        qr, sp;
  logic [KW-1:0]      sk, ek;
  logic [Ab:0]        sidx, sidx1, eidx, eidx1;
  logic [RomW-1:0]    sa, sb, ea, eb;
  logic [2*Fb:0]      sprod_nxt, eprod_nxt;
  logic [RomW-1:0]    s_nxt, e_lin, e_nxt;
  logic [2*Fb+1:0]    mprod;
  logic [Vw-1:0]      v_w, eased_nxt;

  // per stage ready chain
  always_comb begin
    en[Stages-1] = !vld_r[Stages-1] || out_tready;
    for (int k = Stages - 2; k >= 0; k--) begin
      en[k] = !vld_r[k] || en[k+1];
    end
  end

  assign in_tready  = en[0];
  assign out_tvalid = vld_r[Stages-1];
  assign out_tdata  = OutW'(out_eased_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      if (en[0]) vld_r[0] <= in_tvalid;
      for (int k = 1; k < Stages; k++) begin
        if (en[k]) vld_r[k] <= vld_r[k-1];
      end
    end
  end

  // stage 0: clamp progress
  always_comb begin
    t_in = in_tdata[Fb:0];
    side0_nxt = '0;
    side0_nxt.t  = (t_in > One) ? One : t_in;
    side0_nxt.op = in_tuser;
  end

  // stage 1: 10t, spring phase numerator, cubic operand
  always_comb begin
    u_nxt  = (UW'(side0_r.t) << 3) + (UW'(side0_r.t) << 1);
    n2_nxt = (N2W'(side0_r.t) << 5) + (N2W'(side0_r.t) << 3) + NineOne;
    x_nxt  = (side0_r.t < Half) ? side0_r.t[Fb-1:0] : Fb'(One - side0_r.t);
    side1_nxt = side0_r;
    side1_nxt.un = u_nxt[Fb+3:Fb];
  end

  // stage 2: wrap phase into one period, square
  always_comb begin
    if (n2_1_r >= P48) wrap_sel = P48;
    else if (n2_1_r >= P36) wrap_sel = P36;
    else if (n2_1_r >= P24) wrap_sel = P24;
    else if (n2_1_r >= P12) wrap_sel = P12;
    else wrap_sel = '0;
    ph_nxt = PhW'(n2_1_r - wrap_sel);
    xsq    = (2*Fb)'(x1_r) * (2*Fb)'(x1_r);
  end

  // stage 3: reciprocal estimate of phase / 3, cube
  always_comb begin
    qprod = (PhW+RecipW)'(ph2_r) * (PhW+RecipW)'(Recip);
    cprod = (2*Fb)'(xx2_r) * (2*Fb)'(x2_r);
    side3_nxt = side2_r;
    side3_nxt.cube = cprod[2*Fb-3:Fb-2];
  end

  // stage 4: quotient correction
  always_comb begin
    q3m   = PhW'({q0_3_r, 1'b0}) + PhW'(q0_3_r);
    rem   = ph3_r - q3m;
    q_nxt = (rem >= PhW'(3)) ? q0_3_r + QW'(1) : q0_3_r;
  end

  // stage 5: sine phase select and table reads
  always_comb begin
    quad = q4_r[QW-1:Fb];
    qr   = {1'b0, q4_r[Fb-1:0]};
    if (side4_r.op == 3'(aecu_pkg::OP_SPRING)) sp = quad[0] ? One - qr : qr;
    else sp = side4_r.t;
    sk    = KW'(sp) << Ab;
    sidx  = sk[Fb+Ab:Fb];
    sidx1 = (sidx == Last) ? sidx : sidx + (Ab+1)'(1);
    sa    = sin_tab[sidx];
    sb    = sin_tab[sidx1];
    ek    = KW'({1'b0, uf4_r}) << Ab;
    eidx  = ek[Fb+Ab:Fb];
    eidx1 = (eidx == Last) ? eidx : eidx + (Ab+1)'(1);
    ea    = exp_tab[eidx];
    eb    = exp_tab[eidx1];
    side5_nxt = side4_r;
    side5_nxt.qhi = quad[1];
  end

  // stage 6: interpolation products
  always_comb begin
    sprod_nxt = (2*Fb+1)'(sd5_r) * (2*Fb+1)'(sr5_r);
    eprod_nxt = (2*Fb+1)'(ed5_r) * (2*Fb+1)'(er5_r);
  end

  // stage 7: interpolated sine and envelope
  always_comb begin
    s_nxt = sdn6_r ? sa6_r - sprod6_r[2*Fb:Fb] : sa6_r + sprod6_r[2*Fb:Fb];
    e_lin = edn6_r ? ea6_r - eprod6_r[2*Fb:Fb] : ea6_r + eprod6_r[2*Fb:Fb];
    e_nxt = e_lin >> side6_r.un;
  end

  // stage 8: envelope times sine
  assign mprod = (2*Fb+2)'(e7_r) * (2*Fb+2)'(s7_r);

  // stage 9: curve select and saturation
  always_comb begin
    unique case (side8_r.op)
      aecu_pkg::OP_LINEAR: v_w = Vw'(side8_r.t);
      aecu_pkg::OP_CUBIC: begin
        if (side8_r.t < Half) v_w = Vw'(side8_r.cube);
        else v_w = Vw'(One) - Vw'(side8_r.cube);
      end
      aecu_pkg::OP_EXPO: begin
        if (side8_r.t == One) v_w = Vw'(One);
        else v_w = Vw'(One) - Vw'(e8_r);
      end
      aecu_pkg::OP_SPRING: begin
        if (side8_r.t == '0) v_w = '0;
        else if (side8_r.t == One) v_w = Vw'(One);
        else if (side8_r.qhi) v_w = Vw'(One) - Vw'(mag8_r);
        else v_w = Vw'(One) + Vw'(mag8_r);
      end
      default: v_w = Vw'(s8_r);
    endcase
    eased_nxt = v_w[Vw-1] ? Hi : v_w;
  end

  always_ff @(posedge clk) begin
    if (en[0]) side0_r <= side0_nxt;
    if (en[1]) begin
      side1_r <= side1_nxt;
      uf1_r   <= u_nxt[Fb-1:0];
      n2_1_r  <= n2_nxt;
      x1_r    <= x_nxt;
    end
    if (en[2]) begin
      side2_r <= side1_r;
      uf2_r   <= uf1_r;
      ph2_r   <= ph_nxt;
      x2_r    <= x1_r;
      xx2_r   <= xsq[2*Fb-1:Fb];
    end
    if (en[3]) begin
      side3_r <= side3_nxt;
      uf3_r   <= uf2_r;
      ph3_r   <= ph2_r;
      q0_3_r  <= qprod[Sh+QW-1:Sh];
    end
    if (en[4]) begin
      side4_r <= side3_r;
      uf4_r   <= uf3_r;
      q4_r    <= q_nxt;
    end
    if (en[5]) begin
      side5_r <= side5_nxt;
      sa5_r   <= sa;
      sdn5_r  <= sb < sa;
      sd5_r   <= (sb < sa) ? sa - sb : sb - sa;
      sr5_r   <= sk[Fb-1:0];
      ea5_r   <= ea;
      edn5_r  <= eb < ea;
      ed5_r   <= (eb < ea) ? ea - eb : eb - ea;
      er5_r   <= ek[Fb-1:0];
    end
    if (en[6]) begin
      side6_r  <= side5_r;
      sa6_r    <= sa5_r;
      sdn6_r   <= sdn5_r;
      sprod6_r <= sprod_nxt;
      ea6_r    <= ea5_r;
      edn6_r   <= edn5_r;
      eprod6_r <= eprod_nxt;
    end
    if (en[7]) begin
      side7_r <= side6_r;
      s7_r    <= s_nxt;
      e7_r    <= e_nxt;
    end
    if (en[8]) begin
      side8_r <= side7_r;
      s8_r    <= s7_r;
      e8_r    <= e7_r;
      mag8_r  <= mprod[2*Fb:Fb];
    end
    if (en[9]) out_eased_r <= eased_nxt;
  end

endmodule

// ===== sv/aecu_checker.sv =====
// port level checks for the easing curve unit, bound to the top level
module aecu_port_checker #(
  parameter int FRAC_BITS = aecu_pkg::FRAC_BITS_DEF,
  localparam int InW  = ((FRAC_BITS + 8) / 8) * 8,
  localparam int OutW = ((FRAC_BITS + 9) / 8) * 8
) (
  input logic            clk,
  input logic            rst_n,
  input logic            in_tvalid,
  input logic            in_tready,
  input logic [InW-1:0]  in_tdata,   // progress
  input logic [2:0]      in_tuser,   // operation
  input logic            out_tvalid,
  input logic            out_tready,
  input logic [OutW-1:0] out_tdata   // eased
);

  // stalled result stays put
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed or dropped while stalled");

  // free output slot means the pipe can take a new transaction
  a_ready_when_drained: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_tvalid || out_tready) |-> in_tready)
    else $error("input blocked while output side can move");

  // reset empties the pipe
  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

  // eased values are never negative and padding stays zero
  a_out_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[OutW-1:FRAC_BITS+1] == '0)
    else $error("eased value out of range");

endmodule

bind animation_easing_curve_unit aecu_port_checker #(.FRAC_BITS(FRAC_BITS)) u_aecu_checker (.*);
